### sv/stp_pkg.sv
// Shared types and constants for the software timer pool.
package stp_pkg;

  localparam int unsigned SLOTS = 8;
  localparam int unsigned PTR_W = 4;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_REFRESH = 3'd1;
  localparam logic [2:0] OP_CHANGE  = 3'd2;
  localparam logic [2:0] OP_DESTROY = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ACK    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  handle;
    logic [31:0] interval;
    logic [31:0] tag;
  } request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic        status;
    logic [31:0] expired_tag;
    logic [3:0]  active_count;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_WRITE,
    ST_ACK,
    ST_WALK,
    ST_UNLINK,
    ST_PUSH,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath for one cycle.
  typedef struct packed {
    logic  load;
    logic  create;
    logic  write;
    logic  dec;
    logic  latch_next;
    logic  advance;
    logic  unlink;
    logic  push;
    logic  emit;
    kind_t kind;
  } ctl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic req_handle_ok;
    logic is_tick;
    logic walk_end;
    logic cur_match;
    logic dec_zero;
    logic out_free;
  } stat_t;

endpackage

### sv/software_timer_pool.sv
// Top level of the software timer pool: controller plus slot datapath.
//
// Eight countdown timers share one link array: free slots sit on a
// last-in-first-out stack (slot 0 first after reset), active slots on a
// list with the newest first. Requests are create (returns a slot or the
// null handle 8), refresh, change interval, destroy and tick; handles of 8
// or more are null. Every request gives one result, except a tick, which
// gives one expiry result per timer that reaches zero (its slot freed on
// the spot) and then a tick-done result with the number of active timers;
// the last result of a request has last set. A tick turns a count of zero
// into all ones and does not expire it. Refreshing a slot whose interval
// was never loaded gives it an unspecified count. One request is worked on
// at a time and request_stall stays high until its final result has been
// loaded into the output register. Destroy and tick walk the active list
// one link at a time, so their cost grows with the list length. A stall
// on the result side holds the block only where a result is produced,
// not during the list walk or the unlink step.
module software_timer_pool #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_stall,
  input  stp_pkg::request_t  request,
  output logic               result_valid,
  input  logic               result_stall,
  output stp_pkg::result_t   result
);
  import stp_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // Sequence each request: decode, walk the list, emit results.
  stp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_op    (request.operation),
    .request_stall (request_stall),
    .stat          (stat),
    .ctl           (ctl)
  );

  // Hold counts, tags, links and pointers; register each result.
  stp_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ctl          (ctl),
    .stat         (stat)
  );

endmodule

### sv/stp_ctrl.sv
// Controller state machine for the software timer pool.
module stp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  request_valid,
  input  logic [2:0]            request_op,
  output logic                  request_stall,
  input  stp_pkg::stat_t        stat,
  output stp_pkg::ctl_t         ctl
);
  import stp_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign request_stall = (state != ST_IDLE);
  assign accept        = request_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (request_op) inside
            OP_CREATE:             state_next = ST_CREATE;
            OP_REFRESH, OP_CHANGE: state_next = stat.req_handle_ok ? ST_WRITE : ST_ACK;
            OP_DESTROY:            state_next = stat.req_handle_ok ? ST_WALK : ST_ACK;
            OP_TICK:               state_next = ST_WALK;
            default:               state_next = ST_ACK;
          endcase
        end
      end
      ST_CREATE, ST_WRITE, ST_ACK, ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_WALK: begin
        if (stat.walk_end) begin
          state_next = stat.is_tick ? ST_DONE : ST_ACK;
        end else if (stat.is_tick) begin
          if (stat.dec_zero) state_next = ST_UNLINK;
        end else if (stat.cur_match) begin
          state_next = ST_UNLINK;
        end
      end
      ST_UNLINK: state_next = ST_PUSH;
      ST_PUSH: begin
        if (stat.out_free) state_next = stat.is_tick ? ST_WALK : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.kind = KIND_ACK;
    ctl.load = accept;
    unique case (state)
      ST_IDLE: ;
      ST_CREATE: begin
        ctl.create = stat.out_free;
        ctl.emit   = stat.out_free;
        ctl.kind   = KIND_CREATE;
      end
      ST_WRITE: begin
        ctl.write = stat.out_free;
        ctl.emit  = stat.out_free;
      end
      ST_ACK: ctl.emit = stat.out_free;
      ST_DONE: begin
        ctl.emit = stat.out_free;
        ctl.kind = KIND_DONE;
      end
      ST_WALK: begin
        if (!stat.walk_end) begin
          if (stat.is_tick) begin
            ctl.dec        = 1'b1;
            ctl.latch_next = 1'b1;
            ctl.advance    = !stat.dec_zero;
          end else begin
            ctl.latch_next = stat.cur_match;
            ctl.advance    = !stat.cur_match;
          end
        end
      end
      ST_UNLINK: ctl.unlink = 1'b1;
      ST_PUSH: begin
        ctl.push = stat.out_free;
        ctl.emit = stat.out_free;
        ctl.kind = stat.is_tick ? KIND_EXPIRY : KIND_ACK;
      end
      default: ;
    endcase
  end

endmodule

### sv/stp_datapath.sv
// Slot storage, list pointers and result register for the software timer pool.
module stp_datapath #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  stp_pkg::request_t  request,
  output stp_pkg::result_t   result,
  output logic               result_valid,
  input  logic               result_stall,
  input  stp_pkg::ctl_t      ctl,
  output stp_pkg::stat_t     stat
);
  import stp_pkg::*;

  logic [COUNT_BITS-1:0] remaining    [SLOTS];
  logic [COUNT_BITS-1:0] reload_value [SLOTS];
  logic [31:0]           stored_tag   [SLOTS];
  logic [PTR_W-1:0]      link         [SLOTS];

  logic [PTR_W-1:0] free_head;
  logic [CNT_W-1:0] free_count;
  logic [PTR_W-1:0] active_head;
  logic [CNT_W-1:0] active_total;

  logic [2:0]            op_r;
  logic [PTR_W-1:0]      handle_r;
  logic [COUNT_BITS-1:0] ival_r;
  logic [31:0]           tag_r;
  logic [PTR_W-1:0]      cur;
  logic [PTR_W-1:0]      prev;
  logic [PTR_W-1:0]      next_r;
  logic [CNT_W-1:0]      guard;

  logic [IDX_W-1:0]      fh_idx, cur_idx, prev_idx, h_idx, link_rd_idx;
  logic [PTR_W-1:0]      link_rd;
  logic [COUNT_BITS-1:0] dec_val;
  logic                  free_avail;
  logic                  status_null;
  result_t               result_next;

  assign fh_idx      = free_head[IDX_W-1:0];
  assign cur_idx     = cur[IDX_W-1:0];
  assign prev_idx    = prev[IDX_W-1:0];
  assign h_idx       = handle_r[IDX_W-1:0];
  assign link_rd_idx = ctl.create ? fh_idx : cur_idx;
  assign link_rd     = link[link_rd_idx];
  assign dec_val     = remaining[cur_idx] - COUNT_BITS'(1);
  assign free_avail  = (free_count != '0) && (free_head < NULL_PTR);
  assign status_null = ((op_r == OP_REFRESH) || (op_r == OP_CHANGE)) && !(handle_r < NULL_PTR);

  assign stat.req_handle_ok = request.handle < NULL_PTR;
  assign stat.is_tick       = (op_r == OP_TICK);
  assign stat.walk_end      = !(cur < NULL_PTR) || (guard == CNT_W'(SLOTS));
  assign stat.cur_match     = (cur == handle_r);
  assign stat.dec_zero      = (dec_val == '0);
  assign stat.out_free      = !result_valid || !result_stall;

  // Hold the item's fields and start a fresh list walk.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r     <= request.operation;
      handle_r <= request.handle;
      ival_r   <= COUNT_BITS'(request.interval);
      tag_r    <= request.tag;
      cur      <= active_head;
      prev     <= NULL_PTR;
      guard    <= '0;
    end else begin
      if (ctl.latch_next) next_r <= link_rd;
      if (ctl.advance) begin
        prev  <= cur;
        cur   <= link_rd;
        guard <= guard + CNT_W'(1);
      end
      if (ctl.push) begin
        cur   <= next_r;
        guard <= guard + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head    <= '0;
      free_count   <= CNT_W'(SLOTS);
      active_head  <= NULL_PTR;
      active_total <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        remaining[i]  <= '0;
        stored_tag[i] <= '0;
        link[i]       <= PTR_W'(i + 1);
      end
    end else begin
      if (ctl.create && free_avail) begin
        free_head         <= link_rd;
        free_count        <= free_count - CNT_W'(1);
        remaining[fh_idx] <= ival_r;
        stored_tag[fh_idx] <= tag_r;
        link[fh_idx]      <= active_head;
        active_head       <= free_head;
        active_total      <= active_total + CNT_W'(1);
      end
      if (ctl.write) begin
        remaining[h_idx] <= (op_r == OP_CHANGE) ? ival_r : reload_value[h_idx];
      end
      if (ctl.dec) begin
        remaining[cur_idx] <= dec_val;
      end
      // Drop the current slot out of the active list.
      if (ctl.unlink) begin
        if (prev < NULL_PTR) begin
          link[prev_idx] <= next_r;
        end else begin
          active_head <= next_r;
        end
        active_total <= active_total - CNT_W'(1);
      end
      // Return the current slot to the top of the free stack.
      if (ctl.push) begin
        link[cur_idx] <= free_head;
        free_head     <= cur;
        free_count    <= free_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.create && free_avail) begin
      reload_value[fh_idx] <= ival_r;
    end
    if (ctl.write && (op_r == OP_CHANGE)) begin
      reload_value[h_idx] <= ival_r;
    end
  end

  always_comb begin
    result_next              = '0;
    result_next.kind         = ctl.kind;
    result_next.slot         = NULL_PTR;
    result_next.last         = 1'b1;
    case (ctl.kind)
      KIND_CREATE: result_next.slot = free_avail ? free_head : NULL_PTR;
      KIND_EXPIRY: begin
        result_next.slot        = cur;
        result_next.expired_tag = stored_tag[cur_idx];
        result_next.last        = 1'b0;
      end
      KIND_DONE:   result_next.active_count = active_total;
      KIND_ACK:    result_next.status = status_null;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) result <= result_next;
  end

endmodule

### dv/tb.sv
// Self-checking testbench for the software timer pool: shadow predictor plus random traffic.
module tb;
  import stp_pkg::*;

  localparam int RANDOM_ITEMS = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 50;

  // Operation codes that the block answers with a plain acknowledge.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Shadow copy of the pool: predicts the results of each accepted request
  // and compares them, in order, with what comes out of the block.
  class timer_pool_shadow;
    logic [31:0]      count_left [SLOTS];
    logic [31:0]      reload     [SLOTS];
    logic [31:0]      tag_of     [SLOTS];
    logic [PTR_W-1:0] next_ptr   [SLOTS];
    bit               reload_set [SLOTS];
    logic [PTR_W-1:0] free_top;
    logic [PTR_W-1:0] free_size;
    logic [PTR_W-1:0] live_head;
    logic [PTR_W-1:0] live_size;
    result_t          pending_results[$];
    int requests;
    int results_checked;
    int mismatches;
    int expiries;
    int full_creates;
    int null_handles;
    int wraps;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        count_left[i] = '0;
        reload[i]     = '0;
        tag_of[i]     = '0;
        next_ptr[i]   = PTR_W'(i + 1);
        reload_set[i] = 1'b0;
      end
      free_top  = '0;
      free_size = PTR_W'(SLOTS);
      live_head = NULL_PTR;
      live_size = '0;
    endfunction

    function void await_result(kind_t k, logic [PTR_W-1:0] slot, logic status,
                               logic [31:0] tag, logic [3:0] count, logic last);
      result_t r;
      r.kind         = k;
      r.slot         = slot;
      r.status       = status;
      r.expired_tag  = tag;
      r.active_count = count;
      r.last         = last;
      pending_results.push_back(r);
    endfunction

    function void push_free(logic [PTR_W-1:0] s);
      next_ptr[s] = free_top;
      free_top    = s;
      free_size++;
    endfunction

    // Remove s from the active list; tell whether it was there.
    function bit unlink_live(logic [PTR_W-1:0] s);
      logic [PTR_W-1:0] prev;
      logic [PTR_W-1:0] cur;
      prev = NULL_PTR;
      cur  = live_head;
      for (int g = 0; g < SLOTS && cur < SLOTS; g++) begin
        if (cur == s) begin
          if (prev >= SLOTS) live_head = next_ptr[cur];
          else next_ptr[prev] = next_ptr[cur];
          live_size--;
          return 1'b1;
        end
        prev = cur;
        cur  = next_ptr[cur];
      end
      return 1'b0;
    endfunction

    function logic [PTR_W-1:0] random_live();
      logic [PTR_W-1:0] seen[$];
      logic [PTR_W-1:0] cur;
      cur = live_head;
      for (int g = 0; g < SLOTS && cur < SLOTS; g++) begin
        seen.push_back(cur);
        cur = next_ptr[cur];
      end
      if (seen.size() == 0) return NULL_PTR;
      return seen[$urandom_range(0, seen.size() - 1)];
    endfunction

    function void note_request(request_t r);
      logic [PTR_W-1:0] n;
      logic [PTR_W-1:0] prev;
      logic [PTR_W-1:0] cur;
      logic [PTR_W-1:0] nxt;
      bit               ok;
      ok = r.handle < SLOTS;
      requests++;
      case (r.operation)
        OP_CREATE: begin
          if (free_size != 0 && free_top < SLOTS) begin
            n             = free_top;
            free_top      = next_ptr[n];
            free_size--;
            count_left[n] = r.interval;
            reload[n]     = r.interval;
            reload_set[n] = 1'b1;
            tag_of[n]     = r.tag;
            next_ptr[n]   = live_head;
            live_head     = n;
            live_size++;
            await_result(KIND_CREATE, n, 1'b0, '0, '0, 1'b1);
          end else begin
            full_creates++;
            await_result(KIND_CREATE, NULL_PTR, 1'b0, '0, '0, 1'b1);
          end
        end
        OP_REFRESH, OP_CHANGE: begin
          if (!ok) begin
            null_handles++;
            await_result(KIND_ACK, NULL_PTR, 1'b1, '0, '0, 1'b1);
          end else begin
            // Inactive slots are written too; they just never get ticked.
            if (r.operation == OP_CHANGE) begin
              reload[r.handle]     = r.interval;
              reload_set[r.handle] = 1'b1;
            end
            count_left[r.handle] = reload[r.handle];
            await_result(KIND_ACK, NULL_PTR, 1'b0, '0, '0, 1'b1);
          end
        end
        OP_DESTROY: begin
          if (ok && unlink_live(r.handle)) push_free(r.handle);
          await_result(KIND_ACK, NULL_PTR, 1'b0, '0, '0, 1'b1);
        end
        OP_TICK: begin
          prev = NULL_PTR;
          cur  = live_head;
          for (int g = 0; g < SLOTS && cur < SLOTS; g++) begin
            nxt = next_ptr[cur];
            if (count_left[cur] == 0) wraps++;
            count_left[cur] = count_left[cur] - 1;
            if (count_left[cur] == 0) begin
              expiries++;
              await_result(KIND_EXPIRY, cur, 1'b0, tag_of[cur], '0, 1'b0);
              if (prev >= SLOTS) live_head = nxt;
              else next_ptr[prev] = nxt;
              live_size--;
              push_free(cur);
            end else begin
              prev = cur;
            end
            cur = nxt;
          end
          await_result(KIND_DONE, NULL_PTR, 1'b0, '0, live_size, 1'b1);
        end
        default: await_result(KIND_ACK, NULL_PTR, 1'b0, '0, '0, 1'b1);
      endcase
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < PRINT_CAP)
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending (slot)", 32'(got.slot), 32'(NULL_PTR));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report_mismatch("kind", 32'(got.kind), 32'(want.kind));
      if (got.slot !== want.slot)
        report_mismatch("slot", 32'(got.slot), 32'(want.slot));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.expired_tag !== want.expired_tag)
        report_mismatch("expired_tag", got.expired_tag, want.expired_tag);
      if (got.active_count !== want.active_count)
        report_mismatch("active_count", 32'(got.active_count), 32'(want.active_count));
      if (got.last !== want.last)
        report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    task report_leftovers();
      if (pending_results.size() != 0)
        report_mismatch("results never delivered (count)", 32'(pending_results.size()), '0);
    endtask
  endclass

  logic     clk;
  logic     rst;
  logic     request_valid;
  logic     request_stall;
  request_t request;
  logic     result_valid;
  logic     result_stall;
  result_t  result;

  timer_pool_shadow sb;
  int burst_left;
  int cycle_count;
  bit held_off;

  software_timer_pool dut (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request      (request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic request_t mk(logic [2:0] op, logic [3:0] h, logic [31:0] iv,
                                  logic [31:0] tg);
    request_t r;
    r.operation = op;
    r.handle    = h;
    r.interval  = iv;
    r.tag       = tg;
    return r;
  endfunction

  // Mostly short intervals so that timers really expire; some zero to wrap.
  function automatic logic [31:0] pick_interval();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 4);
    if (p < 80) return '0;
    if (p < 90) return $urandom_range(5, 20);
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_handle();
    int               p;
    logic [PTR_W-1:0] h;
    p = $urandom_range(0, 99);
    h = sb.random_live();
    if (p < 60 && h != NULL_PTR) return h;
    if (p < 85) return 4'($urandom_range(0, SLOTS - 1));
    return 4'($urandom_range(SLOTS, 15));
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       p;
    r.tag      = $urandom;
    r.interval = pick_interval();
    r.handle   = pick_handle();
    p = $urandom_range(0, 99);
    if (p < 25) r.operation = OP_CREATE;
    else if (p < 55) r.operation = OP_TICK;
    else if (p < 67) r.operation = OP_REFRESH;
    else if (p < 77) r.operation = OP_CHANGE;
    else if (p < 92) r.operation = OP_DESTROY;
    else r.operation = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    // Never refresh a slot whose reload value has not been loaded yet.
    if (r.operation == OP_REFRESH && r.handle < SLOTS && !sb.reload_set[r.handle])
      r.operation = OP_CHANGE;
    return r;
  endfunction

  // Present one item, hold it until accepted, then idle for a while or go on at once.
  task automatic offer(input request_t r);
    int gap;
    int p;
    request       <= r;
    request_valid <= 1'b1;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 45) gap = 0;
      else if (p < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 25);
    end
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin : stimulus
    sb            = new();
    burst_left    = 0;
    rst           = 1'b1;
    request_valid = 1'b0;
    request       = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Empty pool, null and out-of-range handles, unused codes.
    offer(mk(OP_TICK, NULL_PTR, '0, '0));
    offer(mk(OP_REFRESH, NULL_PTR, 32'd5, 32'd1));
    offer(mk(OP_CHANGE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    offer(mk(OP_DESTROY, NULL_PTR, '0, '0));
    offer(mk(OP_DESTROY, 4'd3, '0, '0));
    offer(mk(OP_UNUSED_LO, 4'd0, 32'hFFFF_FFFF, '0));
    offer(mk(OP_UNUSED_HI, 4'd15, '0, 32'hFFFF_FFFF));
    // Fill the pool with extreme intervals and tags, then overflow it.
    offer(mk(OP_CREATE, NULL_PTR, 32'd1, 32'hFFFF_FFFF));
    offer(mk(OP_CREATE, NULL_PTR, '0, '0));
    offer(mk(OP_CREATE, NULL_PTR, 32'hFFFF_FFFF, 32'hA5A5_A5A5));
    repeat (5) offer(mk(OP_CREATE, NULL_PTR, 32'd2, $urandom));
    offer(mk(OP_CREATE, NULL_PTR, 32'd3, 32'h5A5A_5A5A));
    // Expire one, wrap a zero count, touch live and freed slots.
    offer(mk(OP_TICK, NULL_PTR, '0, '0));
    offer(mk(OP_CHANGE, 4'd1, 32'd1, '0));
    offer(mk(OP_REFRESH, 4'd2, '0, '0));
    offer(mk(OP_DESTROY, 4'd5, '0, '0));
    offer(mk(OP_CHANGE, 4'd0, 32'd3, '0));
    offer(mk(OP_REFRESH, 4'd0, '0, '0));
    offer(mk(OP_TICK, NULL_PTR, '0, '0));
    offer(mk(OP_DESTROY, 4'd2, '0, '0));
    offer(mk(OP_TICK, NULL_PTR, '0, '0));

    for (int i = 0; i < RANDOM_ITEMS; i++) offer(random_request());
    request_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.report_leftovers();

    $display("Covered %0d requests and %0d results: %0d expiries, %0d wrapped counts,",
             sb.requests, sb.results_checked, sb.expiries, sb.wraps);
    $display("%0d creates on a full pool, %0d null handles, output held off %0d cycles once.",
             sb.full_creates, sb.null_handles, HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stall the output side: short stalls, open stretches, a few long ones,
  // and once a long hold-off so the block backs up into its input.
  initial begin : receiver
    int mode;
    held_off     = 1'b0;
    result_stall = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (!held_off && sb.results_checked >= 60) begin
        held_off = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(5, 30)) @(negedge clk);
      end else if (mode < 9) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        result_stall <= 1'b0;
        @(negedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
        result_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, sb.pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
